>>> design/ftss_pkg.sv
// ----------------------------------------------------------------------------
// ftss_pkg
// Shared constants and types for the file transfer sector splitter.
// ----------------------------------------------------------------------------
package ftss_pkg;

    localparam int FTSS_SECTOR_BYTES      = 512;
    localparam int FTSS_FILE_SECTOR_LIMIT = 32;
    localparam int FTSS_QUEUE_DEPTH       = 2;

    localparam int STATUS_W = 3;
    localparam int FILE_W   = 16;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 10;
    localparam int ADDR_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHUNK   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_BADPOS  = 3'd3,
        ST_ERASED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_ERASED = 2'd0,
        REG_SPF    = 2'd1,
        REG_MAIN   = 2'd2,
        REG_BACKUP = 2'd3
    } reg_index_t;

endpackage

>>> design/file_transfer_sector_splitter.sv
// ----------------------------------------------------------------------------
// file_transfer_sector_splitter
// Splits file read/write requests into per-sector device chunks.
// ----------------------------------------------------------------------------
// A request is classified on acceptance and queued (two entries). A request
// refused with a status, or with nothing to transfer, yields one result. A
// request of N chunks is dequeued, then the file base is multiplied, then the
// starting sector is added, then one chunk is sent per cycle while the output
// is not stalled (N is at most FILE_SECTOR_LIMIT). Requests enter at one per
// cycle while the queue has room.
module file_transfer_sector_splitter
    import ftss_pkg::*;
#(
    parameter int SECTOR_BYTES      = FTSS_SECTOR_BYTES,
    parameter int FILE_SECTOR_LIMIT = FTSS_FILE_SECTOR_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [FILE_W-1:0]   s_file_index,
    input  logic signed [31:0]  s_position,
    input  logic [31:0]         s_transfer_length,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [31:0]         m_physical_sector,
    output logic [OFFSET_W-1:0] m_sector_offset,
    output logic [COUNT_W-1:0]  m_chunk_bytes,
    output logic                m_last
);

    localparam int SB_W    = $clog2(SECTOR_BYTES);
    localparam int SPF_W   = $clog2(FILE_SECTOR_LIMIT + 1);
    localparam int FS_W    = SB_W + SPF_W;
    localparam int ENTRY_W = STATUS_W + FILE_W + SPF_W + 2 * FS_W;

    logic        erased_reg;
    logic [5:0]  spf_reg;
    logic [31:0] main_reg;
    logic [31:0] backup_reg;
    logic        cfg_write;
    reg_index_t  cfg_index;

    logic               q_full, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erased_reg <= 1'b0;
            spf_reg    <= 6'd1;
            main_reg   <= 32'd0;
            backup_reg <= 32'd1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ERASED: erased_reg <= pwdata[0];
                REG_SPF:    spf_reg    <= pwdata[5:0];
                REG_MAIN:   main_reg   <= pwdata;
                REG_BACKUP: backup_reg <= pwdata;
                default:    erased_reg <= erased_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_ERASED: prdata = {31'd0, erased_reg};
            REG_SPF:    prdata = {26'd0, spf_reg};
            REG_MAIN:   prdata = main_reg;
            REG_BACKUP: prdata = backup_reg;
            default:    prdata = '0;
        endcase
    end

    ftss_front #(
        .SECTOR_BYTES      (SECTOR_BYTES),
        .FILE_SECTOR_LIMIT (FILE_SECTOR_LIMIT),
        .ENTRY_W           (ENTRY_W)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_file_index      (s_file_index),
        .s_position        (s_position),
        .s_transfer_length (s_transfer_length),
        .erased            (erased_reg),
        .sectors_per_file  (spf_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (q_in)
    );

    ftss_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (FTSS_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    ftss_back #(
        .SECTOR_BYTES      (SECTOR_BYTES),
        .FILE_SECTOR_LIMIT (FILE_SECTOR_LIMIT),
        .ENTRY_W           (ENTRY_W)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_entry             (q_out),
        .q_pop               (q_pop),
        .main_super_sector   (main_reg),
        .backup_super_sector (backup_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_physical_sector   (m_physical_sector),
        .m_sector_offset     (m_sector_offset),
        .m_chunk_bytes       (m_chunk_bytes),
        .m_last              (m_last)
    );

endmodule

>>> design/ftss_queue.sv
// ----------------------------------------------------------------------------
// ftss_queue
// Small register FIFO between the classifier and the chunk sequencer.
// ----------------------------------------------------------------------------
module ftss_queue
    import ftss_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FTSS_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/ftss_front.sv
// ----------------------------------------------------------------------------
// ftss_front
// Request classifier: status checks, file size and length clamp.
// ----------------------------------------------------------------------------
module ftss_front
    import ftss_pkg::*;
#(
    parameter int SECTOR_BYTES      = FTSS_SECTOR_BYTES,
    parameter int FILE_SECTOR_LIMIT = FTSS_FILE_SECTOR_LIMIT,
    parameter int ENTRY_W           = 8
) (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [FILE_W-1:0]  s_file_index,
    input  logic signed [31:0] s_position,
    input  logic [31:0]        s_transfer_length,
    input  logic               erased,
    input  logic [5:0]         sectors_per_file,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_entry
);

    localparam int SB_W  = $clog2(SECTOR_BYTES);
    localparam int SPF_W = $clog2(FILE_SECTOR_LIMIT + 1);
    localparam int FS_W  = SB_W + SPF_W;

    logic [SPF_W-1:0] spf_eff;
    logic [31:0]      fsize, pos_u, remain, len_eff;
    status_t          status;

    always_comb begin
        spf_eff = (32'(sectors_per_file) > 32'(FILE_SECTOR_LIMIT))
                ? SPF_W'(FILE_SECTOR_LIMIT) : SPF_W'(sectors_per_file);
        fsize   = 32'(spf_eff) << SB_W;
        pos_u   = {1'b0, s_position[30:0]};
        remain  = fsize - pos_u;
        len_eff = (s_transfer_length < remain) ? s_transfer_length : remain;

        if (erased) begin
            status = ST_ERASED;
        end else if (s_position[31]) begin
            status = ST_BADPOS;
        end else if (pos_u >= fsize) begin
            status = s_req_type ? ST_NOSPACE : ST_EMPTY;
        end else if (len_eff == '0) begin
            status = ST_EMPTY;
        end else begin
            status = ST_CHUNK;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_entry = {status, s_file_index, spf_eff, FS_W'(pos_u), FS_W'(len_eff)};

endmodule

>>> design/ftss_back.sv
// ----------------------------------------------------------------------------
// ftss_back
// Chunk sequencer: maps sectors, skips superblocks, emits one result a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ftss_back
    import ftss_pkg::*;
#(
    parameter int SECTOR_BYTES      = FTSS_SECTOR_BYTES,
    parameter int FILE_SECTOR_LIMIT = FTSS_FILE_SECTOR_LIMIT,
    parameter int ENTRY_W           = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  logic [ENTRY_W-1:0]  q_entry,
    output logic                q_pop,
    input  logic [31:0]         main_super_sector,
    input  logic [31:0]         backup_super_sector,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [31:0]         m_physical_sector,
    output logic [OFFSET_W-1:0] m_sector_offset,
    output logic [COUNT_W-1:0]  m_chunk_bytes,
    output logic                m_last
);

    localparam int SB_W  = $clog2(SECTOR_BYTES);
    localparam int SPF_W = $clog2(FILE_SECTOR_LIMIT + 1);
    localparam int FS_W  = SB_W + SPF_W;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_ADD  = 4'b0100,
        BK_RUN  = 4'b1000
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [FILE_W-1:0]  file_reg, file_next;
    logic [SPF_W-1:0]   spf_reg, spf_next;
    logic [FS_W-1:0]    pos_reg, pos_next;
    logic [FS_W-1:0]    len_reg, len_next;
    logic [31:0]        sec_reg, sec_next;
    logic [31:0]        lo_reg, lo_next;
    logic [31:0]        hi_reg, hi_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [31:0]         out_sector_reg, out_sector_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    logic [STATUS_W-1:0] q_status;
    logic [FILE_W-1:0]   q_file;
    logic [SPF_W-1:0]    q_spf;
    logic [FS_W-1:0]     q_pos, q_len;

    logic                out_free;
    logic [SB_W-1:0]     off;
    logic [SB_W:0]       room, cnt;
    logic                ge_lo, ge_hi0, ge_hi1;
    logic [1:0]          bump;

    assign {q_status, q_file, q_spf, q_pos, q_len} = q_entry;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        off    = pos_reg[SB_W-1:0];
        room   = (SB_W+1)'(SECTOR_BYTES) - {1'b0, off};
        cnt    = (len_reg < FS_W'(room)) ? (SB_W+1)'(len_reg) : room;
        ge_lo  = sec_reg >= lo_reg;
        ge_hi0 = sec_reg >= hi_reg;
        ge_hi1 = ({1'b0, sec_reg} + 33'd1) >= {1'b0, hi_reg};
        bump   = {1'b0, ge_lo} + {1'b0, (ge_lo ? ge_hi1 : ge_hi0)};
    end

    always_comb begin
        state_next      = state_reg;
        file_next       = file_reg;
        spf_next        = spf_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        sec_next        = sec_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_sector_next = out_sector_reg;
        out_offset_next = out_offset_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_status != ST_CHUNK) begin
                        out_valid_next  = 1'b1;
                        out_status_next = q_status;
                        out_sector_next = '0;
                        out_offset_next = '0;
                        out_count_next  = '0;
                        out_last_next   = 1'b1;
                    end else begin
                        file_next  = q_file;
                        spf_next   = q_spf;
                        pos_next   = q_pos;
                        len_next   = q_len;
                        lo_next    = (main_super_sector < backup_super_sector)
                                   ? main_super_sector : backup_super_sector;
                        hi_next    = (main_super_sector < backup_super_sector)
                                   ? backup_super_sector : main_super_sector;
                        state_next = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                sec_next   = 32'(file_reg) * 32'(spf_reg);
                state_next = BK_ADD;
            end
            BK_ADD: begin
                sec_next   = sec_reg + 32'(pos_reg >> SB_W);
                state_next = BK_RUN;
            end
            BK_RUN: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_CHUNK;
                    out_sector_next = sec_reg + 32'(bump);
                    out_offset_next = OFFSET_W'(off);
                    out_count_next  = COUNT_W'(cnt);
                    len_next        = len_reg - FS_W'(cnt);
                    pos_next        = pos_reg + FS_W'(cnt);
                    sec_next        = sec_reg + 32'd1;
                    out_last_next   = (len_next == '0);
                    if (len_next == '0) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        file_reg       <= file_next;
        spf_reg        <= spf_next;
        pos_reg        <= pos_next;
        len_reg        <= len_next;
        sec_reg        <= sec_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        out_status_reg <= out_status_next;
        out_sector_reg <= out_sector_next;
        out_offset_reg <= out_offset_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_physical_sector = out_sector_reg;
    assign m_sector_offset   = out_offset_reg;
    assign m_chunk_bytes     = out_count_reg;
    assign m_last            = out_last_reg;

endmodule

>>> tb/file_transfer_sector_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_transfer_sector_splitter_tb
// Self-checking bench for the file transfer sector splitter. Requests are
// driven over valid/ready and registers over APB. A scoreboard splits each
// accepted request into the expected sector chunks, and checks every result
// field by field. The bench runs directed corner cases, then random phases
// under several register settings and handshake idle mixes.
// ----------------------------------------------------------------------------
module file_transfer_sector_splitter_tb;
    import ftss_pkg::*;

    class sector_chunk_scoreboard;
        typedef struct {
            status_t             status;
            logic [31:0]         sector;
            logic [OFFSET_W-1:0] offset;
            logic [COUNT_W-1:0]  count;
            logic                last;
        } chunk_t;

        logic        erased_flag   = 1'b0;
        logic [5:0]  spf_setting   = 6'd1;
        logic [31:0] main_sector   = 32'd0;
        logic [31:0] backup_sector = 32'd1;
        chunk_t      expected_chunks[$];
        int          error_count   = 0;

        function void set_register(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_ERASED: erased_flag   = value[0];
                REG_SPF:    spf_setting   = value[5:0];
                REG_MAIN:   main_sector   = value;
                REG_BACKUP: backup_sector = value;
                default:    ;
            endcase
        endfunction

        function int unsigned effective_spf();
            return (spf_setting > FTSS_FILE_SECTOR_LIMIT) ? FTSS_FILE_SECTOR_LIMIT
                                                          : spf_setting;
        endfunction

        function int pending();
            return expected_chunks.size();
        endfunction

        function void push_chunk(status_t st, longint unsigned sector, longint unsigned offset,
                                 longint unsigned count, logic last);
            chunk_t c;
            c.status = st;
            c.sector = sector[31:0];
            c.offset = offset[OFFSET_W-1:0];
            c.count  = count[COUNT_W-1:0];
            c.last   = last;
            expected_chunks.push_back(c);
        endfunction

        // Accepted request: work out the chunks it should produce.
        function void split_request(logic is_write, logic [FILE_W-1:0] file,
                                    logic [31:0] pos, logic [31:0] len);
            longint unsigned spf, fsize, p, remaining, s, lo, hi, offset, count;
            int n;
            spf       = effective_spf();
            fsize     = spf * FTSS_SECTOR_BYTES;
            p         = pos;
            remaining = len;
            lo        = (main_sector < backup_sector) ? main_sector : backup_sector;
            hi        = (main_sector < backup_sector) ? backup_sector : main_sector;
            n         = 0;
            if (erased_flag) begin
                push_chunk(ST_ERASED, 0, 0, 0, 1'b1);
            end else if (pos[31]) begin
                push_chunk(ST_BADPOS, 0, 0, 0, 1'b1);
            end else if (p >= fsize) begin
                push_chunk(is_write ? ST_NOSPACE : ST_EMPTY, 0, 0, 0, 1'b1);
            end else begin
                if (p + remaining > fsize)
                    remaining = fsize - p;
                if (remaining == 0)
                    push_chunk(ST_EMPTY, 0, 0, 0, 1'b1);
                while (remaining > 0 && n < FTSS_FILE_SECTOR_LIMIT) begin
                    offset = p % FTSS_SECTOR_BYTES;
                    count  = FTSS_SECTOR_BYTES - offset;
                    if (remaining < count)
                        count = remaining;
                    remaining -= count;
                    s = file * spf + p / FTSS_SECTOR_BYTES;
                    if (s >= lo)
                        s++;
                    if (s >= hi)
                        s++;
                    push_chunk(ST_CHUNK, s, offset, count, remaining == 0);
                    n++;
                    p += count;
                end
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_chunk(logic [STATUS_W-1:0] st, logic [31:0] sector,
                                  logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] count,
                                  logic last);
            chunk_t c;
            if (expected_chunks.size() == 0) begin
                $error("result with no request outstanding: status %0d sector %0d",
                       st, sector);
                error_count++;
            end else begin
                c = expected_chunks.pop_front();
                check_field("status", 32'(c.status), 32'(st));
                check_field("physical_sector", c.sector, sector);
                check_field("sector_offset", 32'(c.offset), 32'(offset));
                check_field("chunk_bytes", 32'(c.count), 32'(count));
                check_field("last", 32'(c.last), 32'(last));
            end
        endfunction
    endclass

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                psel              = 1'b0;
    logic                penable           = 1'b0;
    logic                pwrite            = 1'b0;
    logic [ADDR_W-1:0]   paddr             = '0;
    logic [31:0]         pwdata            = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic                s_req_type        = 1'b0;
    logic [FILE_W-1:0]   s_file_index      = '0;
    logic signed [31:0]  s_position        = '0;
    logic [31:0]         s_transfer_length = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [31:0]         m_physical_sector;
    logic [OFFSET_W-1:0] m_sector_offset;
    logic [COUNT_W-1:0]  m_chunk_bytes;
    logic                m_last;

    int send_idle_pct = 16;
    int recv_idle_pct = 49;

    sector_chunk_scoreboard sb;

    file_transfer_sector_splitter i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_file_index      (s_file_index),
        .s_position        (s_position),
        .s_transfer_length (s_transfer_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_physical_sector (m_physical_sector),
        .m_sector_offset   (m_sector_offset),
        .m_chunk_bytes     (m_chunk_bytes),
        .m_last            (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_chunk(m_status, m_physical_sector, m_sector_offset, m_chunk_bytes, m_last);
    end

    task automatic send_request(input logic w, input logic [FILE_W-1:0] f,
                                input logic [31:0] pos, input logic [31:0] len);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid           <= 1'b1;
        s_req_type        <= w;
        s_file_index      <= f;
        s_position        <= pos;
        s_transfer_length <= len;
        do @(posedge aclk); while (!s_ready);
        sb.split_request(w, f, pos, len);
    endtask

    task automatic drain_requests();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic apply_setting(input logic e, input logic [5:0] spf,
                                 input logic [31:0] main_s, input logic [31:0] backup_s);
        logic [31:0] values [4];
        drain_requests();
        values = '{32'(e), 32'(spf), main_s, backup_s};
        pwrite <= 1'b1;
        for (int r = 0; r < 4; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            paddr   <= {reg_index_t'(r), 2'b00};
            pwdata  <= values[r];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            sb.set_register(reg_index_t'(r), values[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_super_sector(int unsigned span);
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(span));
        endcase
    endfunction

    task automatic apply_random_setting();
        logic        e;
        logic [5:0]  spf;
        logic [31:0] main_s, backup_s;
        int unsigned span;
        e = ($urandom_range(99) < 10);
        case ($urandom_range(15))
            0:       spf = 6'd0;
            1:       spf = 6'd63;
            2:       spf = 6'd33;
            3:       spf = 6'd1;
            4, 5:    spf = 6'd32;
            default: spf = 6'($urandom_range(1, 32));
        endcase
        span     = 16 * ((spf == 0) ? 1 : ((spf > 32) ? 32 : spf)) + 32;
        main_s   = pick_super_sector(span);
        backup_s = ($urandom_range(5) == 0) ? main_s : pick_super_sector(span);
        apply_setting(e, spf, main_s, backup_s);
    endtask

    task automatic send_random_request();
        logic [FILE_W-1:0] f;
        logic [31:0]       pos, len;
        int unsigned       fsize;
        int                r;
        fsize = sb.effective_spf() * FTSS_SECTOR_BYTES;
        f = ($urandom_range(99) < 70) ? FILE_W'($urandom_range(15)) : FILE_W'($urandom);
        r = $urandom_range(99);
        if (r < 70)
            pos = (fsize > 0) ? 32'($urandom_range(fsize - 1)) : 32'd0;
        else if (r < 78)
            pos = fsize + $urandom_range(3);
        else if (r < 88)
            pos = $urandom | 32'h8000_0000;
        else
            pos = $urandom;
        r = $urandom_range(99);
        if (r < 10)
            len = 32'd0;
        else if (r < 50)
            len = $urandom_range(1, 700);
        else if (r < 90)
            len = $urandom_range(1, fsize + 600);
        else
            len = $urandom;
        send_request(1'($urandom_range(1)), f, pos, len);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        apply_setting(1'b0, 6'd4, 32'd3, 32'd9);
        send_request(1'b0, 16'd0, 32'd0, 32'd2048);
        send_request(1'b1, 16'd1, 32'd100, 32'd1000);
        send_request(1'b0, 16'd2, 32'd511, 32'd2);
        send_request(1'b0, 16'd0, 32'd0, 32'd0);
        send_request(1'b1, 16'd3, 32'd2047, 32'hFFFF_FFFF);
        send_request(1'b0, 16'd1, 32'd2048, 32'd10);
        send_request(1'b1, 16'd1, 32'd2048, 32'd10);
        send_request(1'b0, 16'd0, 32'h7FFF_FFFF, 32'd1);
        send_request(1'b1, 16'd0, 32'h7FFF_FFFF, 32'd1);
        send_request(1'b0, 16'd0, 32'hFFFF_FFFF, 32'd5);
        send_request(1'b1, 16'hFFFF, 32'h8000_0000, 32'd5);
        send_request(1'b1, 16'hFFFF, 32'd0, 32'd512);

        // equal superblocks, full-size file
        apply_setting(1'b0, 6'd32, 32'd5, 32'd5);
        send_request(1'b0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(1'b1, 16'hFFFF, 32'd16383, 32'd1);

        apply_setting(1'b0, 6'd63, 32'hFFFF_FFFF, 32'd0);
        send_request(1'b0, 16'd3, 32'd16000, 32'd1000);
        send_request(1'b1, 16'd3, 32'd16384, 32'd1);

        apply_setting(1'b0, 6'd0, 32'd0, 32'd1);
        send_request(1'b0, 16'd0, 32'd0, 32'd5);
        send_request(1'b1, 16'd0, 32'd0, 32'd5);
        send_request(1'b1, 16'd0, 32'hFFFF_FFFB, 32'd5);

        apply_setting(1'b1, 6'd8, 32'd2, 32'd7);
        send_request(1'b0, 16'd1, 32'd0, 32'd100);
        send_request(1'b1, 16'd1, 32'hFFFF_FFFF, 32'd100);

        for (int phase = 0; phase < 9; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            apply_random_setting();
            for (int i = 0; i < 56; i++) begin
                // hold requests until the pipe empties
                if (i == 28 && phase % 3 == 0)
                    drain_requests();
                send_random_request();
            end
        end

        drain_requests();
        repeat (64) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
design/ftss_pkg.sv
design/ftss_queue.sv
design/ftss_front.sv
design/ftss_back.sv
design/file_transfer_sector_splitter.sv
tb/file_transfer_sector_splitter_tb.sv
